FILE: rtl/core/mpva_pkg.sv
// Shared types, codes and lookup functions of the MIDI parser and voice allocator.
`timescale 1ns / 1ps
package mpva_pkg;

  localparam int NUM_CH    = 16;
  localparam int DEF_SLOTS = 2;

  localparam logic [3:0] DRUM_CH = 4'd9;

  // status bytes
  localparam logic [7:0] SYS_EXCL    = 8'hF0;
  localparam logic [7:0] SYS_EOX     = 8'hF7;
  localparam logic [7:0] SYS_RESET   = 8'hFF;
  localparam logic [7:0] RT_FIRST    = 8'hF8;
  localparam logic [7:0] ONE_DATA_LO = 8'hC0;
  localparam logic [7:0] ONE_DATA_HI = 8'hDF;

  // message kinds, upper nibble of the status
  localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
  localparam logic [3:0] MSG_CC       = 4'hB;
  localparam logic [3:0] MSG_PROGRAM  = 4'hC;
  localparam logic [3:0] MSG_BEND     = 4'hE;

  // controller numbers
  localparam logic [6:0] CC_VOLUME     = 7'd7;
  localparam logic [6:0] CC_PAN        = 7'd10;
  localparam logic [6:0] CC_EXPRESSION = 7'd11;
  localparam logic [6:0] CC_SUSTAIN    = 7'd64;
  localparam logic [6:0] CC_SOUND_OFF  = 7'd120;
  localparam logic [6:0] CC_NOTES_OFF  = 7'd123;

  // per-channel reset values
  localparam logic [6:0]  VOLUME_INIT     = 7'd100;
  localparam logic [6:0]  EXPRESSION_INIT = 7'd127;
  localparam logic [6:0]  PAN_CENTER      = 7'd64;
  localparam logic [13:0] BEND_CENTER     = 14'd8192;

  typedef enum logic [1:0] {
    VS_OFF  = 2'd0,
    VS_PLAY = 2'd1,
    VS_REL  = 2'd2
  } voice_state_t;

  typedef enum logic [1:0] {
    EV_START   = 2'd0,
    EV_DRUM    = 2'd1,
    EV_RELEASE = 2'd2,
    EV_GAIN    = 2'd3
  } event_t;

  // instrument for the upper four bits of the program number
  function automatic logic [3:0] prog_sound(input logic [3:0] idx);
    logic [3:0] snd;
    unique case (idx)
      4'd0:  snd = 4'd0;
      4'd1:  snd = 4'd7;
      4'd2:  snd = 4'd4;
      4'd3:  snd = 4'd10;
      4'd4:  snd = 4'd5;
      4'd5:  snd = 4'd1;
      4'd6:  snd = 4'd1;
      4'd7:  snd = 4'd2;
      4'd8:  snd = 4'd9;
      4'd9:  snd = 4'd9;
      4'd10: snd = 4'd3;
      4'd11: snd = 4'd6;
      4'd12: snd = 4'd6;
      4'd13: snd = 4'd9;
      4'd14: snd = 4'd7;
      default: snd = 4'd7;
    endcase
    return snd;
  endfunction

  // drum code for a note on the drum channel
  function automatic logic [3:0] drum_sound(input logic [6:0] n);
    logic [3:0] snd;
    if (n >= 7'd60 && n <= 7'd87) begin
      snd = 4'd12;
    end else begin
      unique case (n)
        7'd35, 7'd36: snd = 4'd1;
        7'd38, 7'd40: snd = 4'd2;
        7'd42:        snd = 4'd3;
        7'd44:        snd = 4'd5;
        7'd46:        snd = 4'd4;
        7'd41, 7'd43: snd = 4'd6;
        7'd45, 7'd47: snd = 4'd7;
        7'd48, 7'd50: snd = 4'd8;
        7'd49, 7'd57: snd = 4'd9;
        7'd51, 7'd59: snd = 4'd10;
        7'd39:        snd = 4'd11;
        7'd56:        snd = 4'd12;
        default:      snd = 4'd3;
      endcase
    end
    return snd;
  endfunction

endpackage

FILE: rtl/core/mpva_if.sv
// Channel interfaces of the MIDI parser and voice allocator: input items, results, config.
`timescale 1ns / 1ps
interface mpva_item_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] midi_byte;
  logic [4:0] finished_voice;

  modport source (output valid, kind, midi_byte, finished_voice, input ready);
  modport sink   (input valid, kind, midi_byte, finished_voice, output ready);
endinterface

interface mpva_result_if;
  logic             valid;
  logic             ready;
  mpva_pkg::event_t event_res;
  logic [3:0]       channel;
  logic [4:0]       voice_index;
  logic [1:0]       release_mask;
  logic [6:0]       note;
  logic [6:0]       velocity;
  logic [3:0]       sound;
  logic [13:0]      gain;
  logic [6:0]       pan;
  logic [13:0]      bend;

  modport source (output valid, event_res, channel, voice_index, release_mask, note,
                  velocity, sound, gain, pan, bend, input ready);
  modport sink   (input valid, event_res, channel, voice_index, release_mask, note,
                  velocity, sound, gain, pan, bend, output ready);
endinterface

interface mpva_cfg_if;
  logic valid;
  logic ready;
  logic enable;

  modport source (output valid, enable, input ready);
  modport sink   (input valid, enable, output ready);
endinterface

FILE: rtl/core/midi_parser_voice_allocator_unit.sv
// Top level: MIDI running-status parser with per-channel voice allocation.
`timescale 1ns / 1ps
// Usage
//   item   : input transactions. kind 0 carries a MIDI byte, kind 1 reports that
//            voice finished_voice (channel*SLOTS_PER_CHANNEL+slot) went silent.
//   result : at most one event per input transaction: voice start (melodic or
//            drum), release mask for a channel, or channel gain update.
//   cfg    : one-bit enable write; always ready. Write it only while idle.
//            With enable low, MIDI bytes are dropped; finished reports still apply.
// Timing
//   An accepted transaction is held in an input register, then one pass of logic
//   updates parser, channel and voice state and loads the result register.
//   Throughput is one transaction per cycle while results are taken; the loops
//   are the read-modify-write of the parser state and the addressed channel's state.
// Reset
//   rst (synchronous) clears the running status, restores channel defaults and
//   sets every voice off; enable resets low.
// Stall
//   While a result waits, a full input register still drains into the result
//   register if that one is taken in the same cycle; otherwise item.ready drops.
module midi_parser_voice_allocator_unit #(
  parameter int SLOTS_PER_CHANNEL = mpva_pkg::DEF_SLOTS
) (
  input  logic           clk,
  input  logic           rst,
  mpva_cfg_if.sink       cfg,
  mpva_item_if.sink      item,
  mpva_result_if.source  result
);
  import mpva_pkg::*;

  localparam int SW = (SLOTS_PER_CHANNEL > 1) ? $clog2(SLOTS_PER_CHANNEL) : 1;

  // configuration
  logic enabled;

  // input register
  logic       in_vld;
  logic       kind_r;
  logic [7:0] byte_r;
  logic [4:0] fv_r;

  // parser state
  logic [7:0] run_st;
  logic       data_cnt;
  logic [6:0] first_data;
  logic [7:0] run_st_next;
  logic       data_cnt_next;
  logic       fd_load;

  // channel state
  logic [6:0]  chan_program    [NUM_CH];
  logic [6:0]  chan_volume     [NUM_CH];
  logic [6:0]  chan_expression [NUM_CH];
  logic [6:0]  chan_pan        [NUM_CH];
  logic [13:0] chan_bend       [NUM_CH];
  logic        chan_sustain    [NUM_CH];

  // voice state
  voice_state_t vstat [NUM_CH][SLOTS_PER_CHANNEL];
  logic [6:0]   vnote [NUM_CH][SLOTS_PER_CHANNEL];

  // flow
  logic can_go;
  logic adv;

  // message decode
  logic       midi_ok;
  logic       one_data;
  logic       msg_fire;
  logic [6:0] d0;
  logic [6:0] d1;
  logic [3:0] ch;
  logic [3:0] op;
  logic       drum;

  logic [SLOTS_PER_CHANNEL-1:0] play_hit;
  logic [SLOTS_PER_CHANNEL-1:0] play_any;
  logic [SLOTS_PER_CHANNEL-1:0] off_hit;
  logic [SLOTS_PER_CHANNEL-1:0] rel_hit;
  logic [SW-1:0]                play_slot;
  logic [SW-1:0]                off_slot;
  logic [SW-1:0]                rel_slot;
  logic [SW-1:0]                slot;

  logic                         do_start;
  logic                         rel_note;
  logic                         rel_all;
  logic                         wr_vol;
  logic                         wr_expr;
  logic                         wr_pan;
  logic                         wr_sus;
  logic                         wr_prog;
  logic                         wr_bend;
  logic                         gain_ev;
  logic [SLOTS_PER_CHANNEL-1:0] rel_mask;
  logic [SLOTS_PER_CHANNEL+1:0] mask_pad;
  voice_state_t                 row_next [SLOTS_PER_CHANNEL];

  logic [6:0]  vol_eff;
  logic [6:0]  expr_eff;
  logic [13:0] gain_val;
  logic [31:0] vidx_full;
  logic        has_res;

  // ---------------------------------------------------------------- config
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
    end else if (cfg.valid) begin
      enabled <= cfg.enable;
    end
  end

  // ---------------------------------------------------------------- flow
  assign can_go     = !result.valid || result.ready;
  assign adv        = in_vld && can_go;
  assign item.ready = !in_vld || can_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (item.ready) begin
      in_vld <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      kind_r <= item.kind;
      byte_r <= item.midi_byte;
      fv_r   <= item.finished_voice;
    end
  end

  // ---------------------------------------------------------------- parser
  assign midi_ok  = !kind_r && enabled;
  assign one_data = (run_st >= ONE_DATA_LO) && (run_st <= ONE_DATA_HI);
  assign msg_fire = midi_ok && !byte_r[7] && (run_st != 8'd0) && (one_data || data_cnt);
  assign d0       = one_data ? byte_r[6:0] : first_data;
  assign d1       = one_data ? 7'd0 : byte_r[6:0];
  assign ch       = run_st[3:0];
  assign op       = run_st[7:4];
  assign drum     = (ch == DRUM_CH);

  always_comb begin
    run_st_next   = run_st;
    data_cnt_next = data_cnt;
    fd_load       = 1'b0;
    if (midi_ok) begin
      if (byte_r[7]) begin
        if (byte_r == SYS_EXCL || byte_r == SYS_EOX || byte_r == SYS_RESET) begin
          run_st_next   = 8'd0;
          data_cnt_next = 1'b0;
        end else if (byte_r < RT_FIRST) begin
          run_st_next   = byte_r;
          data_cnt_next = 1'b0;
        end
      end else if (run_st != 8'd0 && !one_data) begin
        // two-byte message: hold the first byte, fire on the second
        fd_load       = !data_cnt;
        data_cnt_next = !data_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_st   <= 8'd0;
      data_cnt <= 1'b0;
    end else if (adv) begin
      run_st   <= run_st_next;
      data_cnt <= data_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && fd_load) begin
      first_data <= byte_r[6:0];
    end
  end

  // ---------------------------------------------------------------- voice search
  always_comb begin
    for (int s = 0; s < SLOTS_PER_CHANNEL; s++) begin
      play_any[s] = (vstat[ch][s] == VS_PLAY);
      play_hit[s] = play_any[s] && (vnote[ch][s] == d0);
      off_hit[s]  = (vstat[ch][s] == VS_OFF);
      rel_hit[s]  = (vstat[ch][s] == VS_REL);
    end
  end

  // lowest slot wins in each class
  always_comb begin
    play_slot = '0;
    off_slot  = '0;
    rel_slot  = '0;
    for (int s = SLOTS_PER_CHANNEL - 1; s >= 0; s--) begin
      if (play_hit[s]) play_slot = SW'(s);
      if (off_hit[s])  off_slot  = SW'(s);
      if (rel_hit[s])  rel_slot  = SW'(s);
    end
  end

  always_comb begin
    priority if (|play_hit) slot = play_slot;
    else if (|off_hit)      slot = off_slot;
    else if (|rel_hit)      slot = rel_slot;
    else                    slot = '0;
  end

  // ---------------------------------------------------------------- message decode
  always_comb begin
    do_start = 1'b0;
    rel_note = 1'b0;
    rel_all  = 1'b0;
    wr_vol   = 1'b0;
    wr_expr  = 1'b0;
    wr_pan   = 1'b0;
    wr_sus   = 1'b0;
    wr_prog  = 1'b0;
    wr_bend  = 1'b0;
    gain_ev  = 1'b0;
    if (msg_fire) begin
      unique case (op)
        MSG_NOTE_ON: begin
          if (d1 != 7'd0) do_start = 1'b1;
          else            rel_note = !chan_sustain[ch];
        end
        MSG_NOTE_OFF: rel_note = !chan_sustain[ch];
        MSG_CC: begin
          if (d0 == CC_VOLUME) begin
            wr_vol  = 1'b1;
            gain_ev = 1'b1;
          end else if (d0 == CC_EXPRESSION) begin
            wr_expr = 1'b1;
            gain_ev = 1'b1;
          end else if (d0 == CC_PAN) begin
            wr_pan = 1'b1;
          end else if (d0 == CC_SUSTAIN) begin
            wr_sus  = 1'b1;
            rel_all = (d1 == 7'd0);
          end else if (d0 == CC_SOUND_OFF || d0 == CC_NOTES_OFF) begin
            rel_all = 1'b1;
          end
        end
        MSG_PROGRAM: wr_prog = 1'b1;
        MSG_BEND:    wr_bend = 1'b1;
        default: ;
      endcase
    end
  end

  assign rel_mask = rel_all ? play_any : (rel_note ? play_hit : '0);
  assign mask_pad = {2'b00, rel_mask};

  always_comb begin
    for (int s = 0; s < SLOTS_PER_CHANNEL; s++) begin
      if (do_start && slot == SW'(s)) row_next[s] = VS_PLAY;
      else if (rel_mask[s])           row_next[s] = VS_REL;
      else                            row_next[s] = vstat[ch][s];
    end
  end

  assign vol_eff   = wr_vol  ? d1 : chan_volume[ch];
  assign expr_eff  = wr_expr ? d1 : chan_expression[ch];
  assign gain_val  = {7'd0, vol_eff} * {7'd0, expr_eff};
  assign vidx_full = 32'(ch) * 32'(SLOTS_PER_CHANNEL) + 32'(slot);
  assign has_res   = do_start || gain_ev || (|rel_mask);

  // ---------------------------------------------------------------- state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CH; c++) begin
        chan_program[c]    <= 7'd0;
        chan_volume[c]     <= VOLUME_INIT;
        chan_expression[c] <= EXPRESSION_INIT;
        chan_pan[c]        <= PAN_CENTER;
        chan_bend[c]       <= BEND_CENTER;
        chan_sustain[c]    <= 1'b0;
      end
    end else if (adv) begin
      if (wr_vol)  chan_volume[ch]     <= d1;
      if (wr_expr) chan_expression[ch] <= d1;
      if (wr_pan)  chan_pan[ch]        <= d1;
      if (wr_sus)  chan_sustain[ch]    <= (d1 != 7'd0);
      if (wr_prog) chan_program[ch]    <= d0;
      if (wr_bend) chan_bend[ch]       <= {d1, d0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CH; c++) begin
        for (int s = 0; s < SLOTS_PER_CHANNEL; s++) begin
          vstat[c][s] <= VS_OFF;
        end
      end
    end else if (adv) begin
      if (kind_r) begin
        // finished report: an index past the last voice matches nothing
        for (int c = 0; c < NUM_CH; c++) begin
          for (int s = 0; s < SLOTS_PER_CHANNEL; s++) begin
            if (32'(fv_r) == 32'(c * SLOTS_PER_CHANNEL + s)) vstat[c][s] <= VS_OFF;
          end
        end
      end else begin
        for (int s = 0; s < SLOTS_PER_CHANNEL; s++) begin
          vstat[ch][s] <= row_next[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && do_start) begin
      vnote[ch][slot] <= d0;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (can_go) begin
      result.valid <= in_vld && has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && has_res) begin
      result.channel      <= ch;
      result.voice_index  <= 5'd0;
      result.release_mask <= 2'd0;
      result.note         <= 7'd0;
      result.velocity     <= 7'd0;
      result.sound        <= 4'd0;
      result.gain         <= 14'd0;
      result.pan          <= 7'd0;
      result.bend         <= 14'd0;
      if (do_start) begin
        result.event_res   <= drum ? EV_DRUM : EV_START;
        result.voice_index <= vidx_full[4:0];
        result.note        <= d0;
        result.velocity    <= d1;
        result.sound       <= drum ? drum_sound(d0) : prog_sound(chan_program[ch][6:3]);
        result.gain        <= gain_val;
        result.pan         <= drum ? PAN_CENTER : chan_pan[ch];
        result.bend        <= chan_bend[ch];
      end else if (gain_ev) begin
        result.event_res <= EV_GAIN;
        result.gain      <= gain_val;
      end else begin
        result.event_res    <= EV_RELEASE;
        result.release_mask <= mask_pad[1:0];
      end
    end
  end

  // ---------------------------------------------------------------- assertions
  a_start_velocity: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.event_res == EV_START || result.event_res == EV_DRUM)
      |-> result.velocity != 7'd0)
    else $error("voice start with zero velocity");

  a_release_mask: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.event_res == EV_RELEASE |-> result.release_mask != 2'd0)
    else $error("release event without any slot");

  a_pending_data: assert property (@(posedge clk) disable iff (rst)
    data_cnt |-> run_st[7] && !one_data)
    else $error("pending data byte without a two-byte running status");

  a_status_form: assert property (@(posedge clk) disable iff (rst)
    run_st != 8'd0 |-> run_st[7])
    else $error("running status holds a data byte");

endmodule
